@@ sv/ffa_pkg.sv @@
// Shared constants and types of the first-fit arena allocator.
`timescale 1ns / 1ps
package ffa_pkg;
	localparam int ARENA_DEPTH = 4096;
	localparam int AW = $clog2(ARENA_DEPTH);
	localparam int CW = AW + 1;
	localparam int HDR_BYTES = 12;
	localparam int OFS_NEXT = 0;
	localparam int OFS_PREV = 4;
	localparam int OFS_SIZE = 8;
	localparam int WQ_DEPTH = 5;

	typedef enum logic [1:0] {
		FN_ALLOC = 2'd0,
		FN_FREE  = 2'd1,
		FN_FILL  = 2'd2,
		FN_READ  = 2'd3
	} func_t;

	typedef enum logic [4:0] {
		ST_CLR, ST_IDLE, ST_WRD, ST_RUN, ST_WQ, ST_BRD, ST_BRD2,
		ST_A0, ST_A1, ST_A2,
		ST_F0, ST_F1, ST_F2, ST_F3, ST_F4,
		ST_L0, ST_L1, ST_L2,
		ST_RESP
	} st_t;

	typedef struct packed {
		logic          we;
		logic          re;
		logic [AW-1:0] addr;
		logic [7:0]    wdata;
	} mem_req_t;

	typedef struct packed {
		logic          valid;
		logic [AW-1:0] data;
	} resp_t;
endpackage

@@ sv/ffa_ram.sv @@
// Byte-wide arena memory, one port, registered read data.
`timescale 1ns / 1ps
module ffa_ram
	import ffa_pkg::*;
(
	input  logic     clk,
	input  mem_req_t req,
	output logic [7:0] rdata
);
	logic [7:0] mem [ARENA_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.addr];
		end
	end
endmodule

@@ sv/ffa_ctrl.sv @@
// Command sequencer: list walk, word and byte-run access to the arena memory.
`timescale 1ns / 1ps
module ffa_ctrl
	import ffa_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [1:0]    func,
	input  logic [CW-1:0] size,
	input  logic [AW-1:0] index,
	input  logic [7:0]    value,
	input  logic          cfg_valid,
	input  logic [CW-1:0] cfg_data,
	input  logic          out_free,
	output resp_t         resp,
	output mem_req_t      mem_req,
	input  logic [7:0]    rdata
);
	st_t st_q, st_d, ret_q, ret_d;
	logic [CW-1:0] abu_q;
	logic [AW-1:0] first_q;
	logic          empty_q;
	logic [AW-1:0] clr_q;

	logic [CW-1:0] size_q;
	logic [AW-1:0] index_q;
	logic [7:0]    value_q;
	logic [AW-1:0] op_a_q;
	logic [2:0]    k_q;
	logic [31:0]   rw_q;
	logic [AW-1:0] pos_q;
	logic [CW-1:0] run_n_q;
	logic [7:0]    run_v_q;
	logic [AW-1:0] wq_a_q [WQ_DEPTH];
	logic [31:0]   wq_d_q [WQ_DEPTH];
	logic [2:0]    wq_n_q, wq_i_q;
	logic [1:0]    wk_q;
	logic [AW-1:0] cur_q, hdr_q;
	logic [CW-1:0] steps_q, rem_q, visits_q;
	logic [31:0]   lnk_q;
	logic [AW-1:0] res_q;

	logic [CW:0]   need;
	logic [CW-1:0] lim;
	logic          a_nofit, first_fit, fit_end, gap, is_first, is_last, ds_ge;
	logic [33:0]   endv;
	logic [AW-1:0] nb, in_hdr, cap_sel;
	logic [CW-1:0] cap;
	logic [31:0]   szw;

	assign need      = {1'b0, size_q} + (CW+1)'(HDR_BYTES);
	assign lim       = (abu_q > CW'(ARENA_DEPTH)) ? CW'(ARENA_DEPTH) : abu_q;
	assign a_nofit   = {1'b0, lim} < need;
	assign first_fit = {2'b0, first_q} >= need;
	assign endv      = {22'b0, cur_q} + 34'(HDR_BYTES) + {2'b0, rw_q};
	assign nb        = endv[AW-1:0];
	assign fit_end   = ({1'b0, endv} + 35'(need)) <= 35'(lim);
	assign gap       = ({2'b0, lnk_q} >= endv) && (({2'b0, lnk_q} - endv) >= 34'(need));
	assign in_hdr    = index - AW'(HDR_BYTES);
	assign cap       = (rw_q > 32'(ARENA_DEPTH)) ? CW'(ARENA_DEPTH) : rw_q[CW-1:0];
	assign cap_sel   = index_q;
	assign is_first  = hdr_q == first_q;
	assign is_last   = lnk_q == 32'd0;
	assign ds_ge     = rw_q >= 32'(rem_q);
	assign szw       = 32'(size_q);

	// next state; ret_d is where a memory subroutine hands back
	always_comb begin
		st_d  = st_q;
		ret_d = ret_q;
		case (st_q)
			ST_CLR: if (clr_q == AW'(ARENA_DEPTH - 1)) st_d = ST_IDLE;
			ST_IDLE: if (in_valid) begin
				case (func_t'(func))
					FN_ALLOC: st_d = ST_A0;
					FN_FREE: begin st_d = ST_WRD; ret_d = ST_F0; end
					FN_FILL: begin st_d = ST_WRD; ret_d = ST_L0; end
					default: st_d = ST_BRD;
				endcase
			end
			ST_WRD: if (k_q == 3'd4) st_d = ret_q;
			ST_RUN: if (run_n_q <= CW'(1)) st_d = ret_q;
			ST_WQ: if (wk_q == 2'd3 && wq_i_q == wq_n_q - 3'd1) st_d = ret_q;
			ST_BRD: st_d = ST_BRD2;
			ST_BRD2: st_d = ST_RESP;
			ST_A0: begin
				if (a_nofit) st_d = ST_RESP;
				else if (empty_q || first_fit) begin st_d = ST_WQ; ret_d = ST_RESP; end
				else begin st_d = ST_WRD; ret_d = ST_A1; end
			end
			ST_A1: begin st_d = ST_WRD; ret_d = ST_A2; end
			ST_A2: begin
				if (is_last) begin
					if (fit_end) begin st_d = ST_WQ; ret_d = ST_RESP; end
					else st_d = ST_RESP;
				end else if (gap) begin
					st_d = ST_WQ; ret_d = ST_RESP;
				end else if (steps_q == CW'(ARENA_DEPTH - 1)) begin
					st_d = ST_RESP;
				end else begin
					st_d = ST_WRD; ret_d = ST_A1;
				end
			end
			ST_F0: begin st_d = ST_RUN; ret_d = ST_F1; end
			ST_F1: begin st_d = ST_WQ; ret_d = ST_F2; end
			ST_F2: begin
				if (empty_q) st_d = ST_RESP;
				else begin st_d = ST_WRD; ret_d = ST_F3; end
			end
			ST_F3: begin st_d = ST_WRD; ret_d = ST_F4; end
			ST_F4: begin
				if (is_first && is_last) st_d = ST_RESP;
				else begin st_d = ST_WQ; ret_d = ST_RESP; end
			end
			ST_L0: begin
				if (rem_q == '0 || visits_q > CW'(ARENA_DEPTH)) st_d = ST_RESP;
				else if (ds_ge) begin st_d = ST_RUN; ret_d = ST_RESP; end
				else begin st_d = ST_RUN; ret_d = ST_L1; end
			end
			ST_L1: begin st_d = ST_WRD; ret_d = ST_L2; end
			ST_L2: begin
				if (rw_q == 32'd0) st_d = ST_RESP;
				else begin st_d = ST_WRD; ret_d = ST_L0; end
			end
			ST_RESP: if (out_free) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
		if (cfg_valid) st_d = ST_CLR;
	end

	// memory port and handshake outputs
	always_comb begin
		mem_req = '0;
		case (st_q)
			ST_CLR: begin
				mem_req.we   = 1'b1;
				mem_req.addr = clr_q;
			end
			ST_WRD: begin
				mem_req.re   = k_q != 3'd4;
				mem_req.addr = op_a_q + AW'(k_q[1:0]);
			end
			ST_RUN: begin
				mem_req.we    = run_n_q != '0;
				mem_req.addr  = pos_q;
				mem_req.wdata = run_v_q;
			end
			ST_WQ: begin
				mem_req.we    = 1'b1;
				mem_req.addr  = wq_a_q[wq_i_q] + AW'(wk_q);
				mem_req.wdata = 8'(wq_d_q[wq_i_q] >> {wk_q, 3'b000});
			end
			ST_BRD: begin
				mem_req.re   = 1'b1;
				mem_req.addr = op_a_q;
			end
			default: mem_req = '0;
		endcase
	end

	assign in_stall   = st_q != ST_IDLE;
	assign resp.valid = (st_q == ST_RESP) && out_free;
	assign resp.data  = res_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_CLR;
			ret_q   <= ST_RESP;
			abu_q   <= CW'(ARENA_DEPTH);
			first_q <= '0;
			empty_q <= 1'b1;
			clr_q   <= '0;
		end else begin
			st_q  <= st_d;
			ret_q <= ret_d;
			if (st_q == ST_CLR) clr_q <= clr_q + AW'(1);
			if (st_q == ST_A0 && !a_nofit) begin
				if (empty_q) empty_q <= 1'b0;
				else if (first_fit) first_q <= '0;
			end
			if (st_q == ST_F4) begin
				if (is_first && is_last) begin
					empty_q <= 1'b1;
					first_q <= '0;
				end else if (is_first) begin
					first_q <= lnk_q[AW-1:0];
				end
			end
			if (cfg_valid) begin
				abu_q   <= cfg_data;
				first_q <= '0;
				empty_q <= 1'b1;
				clr_q   <= '0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: if (in_valid) begin
				size_q  <= size;
				index_q <= index;
				value_q <= value;
				res_q   <= '0;
				hdr_q   <= in_hdr;
				pos_q   <= index;
				rem_q   <= size;
				visits_q <= '0;
				k_q     <= '0;
				op_a_q  <= (func_t'(func) == FN_READ) ? index : in_hdr + AW'(OFS_SIZE);
			end
			ST_WRD: begin
				k_q <= k_q + 3'd1;
				case (k_q)
					3'd1: rw_q[7:0]   <= rdata;
					3'd2: rw_q[15:8]  <= rdata;
					3'd3: rw_q[23:16] <= rdata;
					3'd4: rw_q[31:24] <= rdata;
					default: ;
				endcase
			end
			ST_RUN: if (run_n_q != '0) begin
				pos_q   <= pos_q + AW'(1);
				run_n_q <= run_n_q - CW'(1);
			end
			ST_WQ: begin
				wk_q <= wk_q + 2'd1;
				if (wk_q == 2'd3) wq_i_q <= wq_i_q + 3'd1;
			end
			ST_BRD2: res_q <= AW'(rdata);
			ST_A0: begin
				wq_i_q <= '0;
				wk_q   <= '0;
				k_q    <= '0;
				cur_q  <= first_q;
				op_a_q <= first_q + AW'(OFS_NEXT);
				steps_q <= '0;
				res_q  <= AW'(HDR_BYTES);
				if (empty_q) begin
					wq_n_q <= 3'd3;
					wq_a_q[0] <= AW'(OFS_NEXT); wq_d_q[0] <= '0;
					wq_a_q[1] <= AW'(OFS_PREV); wq_d_q[1] <= '0;
					wq_a_q[2] <= AW'(OFS_SIZE); wq_d_q[2] <= szw;
				end else begin
					wq_n_q <= 3'd4;
					wq_a_q[0] <= first_q + AW'(OFS_PREV); wq_d_q[0] <= '0;
					wq_a_q[1] <= AW'(OFS_NEXT); wq_d_q[1] <= 32'(first_q);
					wq_a_q[2] <= AW'(OFS_PREV); wq_d_q[2] <= '0;
					wq_a_q[3] <= AW'(OFS_SIZE); wq_d_q[3] <= szw;
				end
				if (a_nofit) res_q <= '0;
			end
			ST_A1: begin
				lnk_q  <= rw_q;
				k_q    <= '0;
				op_a_q <= cur_q + AW'(OFS_SIZE);
			end
			ST_A2: begin
				wq_i_q <= '0;
				wk_q   <= '0;
				k_q    <= '0;
				res_q  <= nb + AW'(HDR_BYTES);
				wq_a_q[0] <= nb + AW'(OFS_NEXT); wq_d_q[0] <= lnk_q;
				wq_a_q[1] <= nb + AW'(OFS_PREV); wq_d_q[1] <= 32'(cur_q);
				wq_a_q[2] <= nb + AW'(OFS_SIZE); wq_d_q[2] <= szw;
				wq_a_q[3] <= cur_q + AW'(OFS_NEXT); wq_d_q[3] <= 32'(nb);
				wq_a_q[4] <= lnk_q[AW-1:0] + AW'(OFS_PREV); wq_d_q[4] <= 32'(nb);
				wq_n_q <= is_last ? 3'd4 : 3'd5;
				if (is_last ? !fit_end : !gap) res_q <= '0;
				cur_q   <= lnk_q[AW-1:0];
				op_a_q  <= lnk_q[AW-1:0] + AW'(OFS_NEXT);
				steps_q <= steps_q + CW'(1);
			end
			ST_F0: begin
				pos_q   <= cap_sel;
				run_n_q <= cap;
				run_v_q <= 8'd0;
			end
			ST_F1: begin
				wq_i_q <= '0;
				wk_q   <= '0;
				wq_n_q <= 3'd1;
				wq_a_q[0] <= hdr_q + AW'(OFS_SIZE); wq_d_q[0] <= '0;
			end
			ST_F2: begin
				k_q    <= '0;
				op_a_q <= hdr_q + AW'(OFS_NEXT);
			end
			ST_F3: begin
				lnk_q  <= rw_q;
				k_q    <= '0;
				op_a_q <= hdr_q + AW'(OFS_PREV);
			end
			ST_F4: begin
				wq_i_q <= '0;
				wk_q   <= '0;
				if (is_first) begin
					wq_n_q <= 3'd2;
					wq_a_q[0] <= lnk_q[AW-1:0] + AW'(OFS_PREV); wq_d_q[0] <= '0;
					wq_a_q[1] <= hdr_q + AW'(OFS_NEXT); wq_d_q[1] <= '0;
				end else if (is_last) begin
					wq_n_q <= 3'd2;
					wq_a_q[0] <= rw_q[AW-1:0] + AW'(OFS_NEXT); wq_d_q[0] <= '0;
					wq_a_q[1] <= hdr_q + AW'(OFS_PREV); wq_d_q[1] <= '0;
				end else begin
					wq_n_q <= 3'd4;
					wq_a_q[0] <= rw_q[AW-1:0] + AW'(OFS_NEXT); wq_d_q[0] <= lnk_q;
					wq_a_q[1] <= lnk_q[AW-1:0] + AW'(OFS_PREV); wq_d_q[1] <= rw_q;
					wq_a_q[2] <= hdr_q + AW'(OFS_NEXT); wq_d_q[2] <= '0;
					wq_a_q[3] <= hdr_q + AW'(OFS_PREV); wq_d_q[3] <= '0;
				end
			end
			ST_L0: begin
				run_v_q <= value_q;
				if (ds_ge) begin
					run_n_q <= rem_q;
				end else begin
					// ds is below rem here, so it fits the count
					run_n_q <= rw_q[CW-1:0];
					rem_q   <= rem_q - rw_q[CW-1:0];
				end
			end
			ST_L1: begin
				k_q    <= '0;
				op_a_q <= hdr_q + AW'(OFS_NEXT);
			end
			ST_L2: begin
				k_q      <= '0;
				hdr_q    <= rw_q[AW-1:0];
				op_a_q   <= rw_q[AW-1:0] + AW'(OFS_SIZE);
				pos_q    <= rw_q[AW-1:0] + AW'(HDR_BYTES);
				visits_q <= visits_q + CW'(1);
			end
			default: ;
		endcase
	end
endmodule

@@ sv/first_fit_arena_allocator_top.sv @@
// Top level of the first-fit arena allocator: sequencer, arena memory, result register.
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------
//  in      | in_valid / in_stall | func, size, index, value
//  out     | out_valid/out_stall | result
//  cfg     | cfg_valid/cfg_ready | arena_bytes_used
//
// One item at a time; every arena access is one byte through a single memory port.
// Read fetches one byte. Alloc reads two header words per block walked, then writes header words.
// Free and fill read and write header words byte by byte and write the data bytes one at a time.
// After reset and after each cfg write a clearing pass zeroes the whole arena;
// in_stall is high during it. One finished item may wait in the result register
// while the next item is accepted.
`timescale 1ns / 1ps
module first_fit_arena_allocator_top
	import ffa_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [1:0]    func,
	input  logic [CW-1:0] size,
	input  logic [AW-1:0] index,
	input  logic [7:0]    value,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [AW-1:0] result,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [CW-1:0] arena_bytes_used
);
	mem_req_t      mem_req;
	logic [7:0]    rdata;
	resp_t         resp;
	logic          out_valid_q;
	logic [AW-1:0] result_q;
	logic          out_free;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;

	ffa_ram u_ram (
		.clk   (clk),
		.req   (mem_req),
		.rdata (rdata)
	);

	ffa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.size      (size),
		.index     (index),
		.value     (value),
		.cfg_valid (cfg_valid),
		.cfg_data  (arena_bytes_used),
		.out_free  (out_free),
		.resp      (resp),
		.mem_req   (mem_req),
		.rdata     (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (resp.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (resp.valid) result_q <= resp.data;
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;

	// an accepted item keeps the input side busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken twice in a row");

	// a new result never overwrites one that is still stalled
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		resp.valid |-> !(out_valid_q && out_stall))
		else $error("result register overwritten");

	// a configuration write starts the clearing pass
	a_cfg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> in_stall)
		else $error("no clearing pass after configuration");

	// memory port never reads and writes in one cycle
	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_req.we && mem_req.re))
		else $error("memory read and write together");
endmodule

@@ bench/first_fit_arena_allocator_top_tb.sv @@
// Self-checking testbench for the first-fit arena allocator top level.
`timescale 1ns / 1ps
module first_fit_arena_allocator_top_tb;
	import ffa_pkg::*;

	localparam int WATCHDOG_LIMIT = 400000;

	logic          clk;
	logic          arst_n;
	logic          in_valid;
	logic          in_stall;
	logic [1:0]    func;
	logic [CW-1:0] size;
	logic [AW-1:0] index;
	logic [7:0]    value;
	logic          out_valid;
	logic          out_stall;
	logic [AW-1:0] result;
	logic          cfg_valid;
	logic          cfg_ready;
	logic [CW-1:0] arena_bytes_used;

	first_fit_arena_allocator_top u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .size(size), .index(index), .value(value),
		.out_valid(out_valid), .out_stall(out_stall), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.arena_bytes_used(arena_bytes_used)
	);

	// shadow arena state
	logic [7:0]    mirror_mem [ARENA_DEPTH];
	logic [31:0]   mirror_first;
	bit            mirror_empty;
	logic [CW-1:0] mirror_used;

	logic [AW-1:0] expected_results [$];
	int            live_blocks [$];   // data indexes of allocated blocks
	bit            failed;
	int            idle_cycles;
	int            hold_off;          // receiver long stall, cycles
	bit            sender_burst_gaps;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int wrap(longint a);
		return int'(a % ARENA_DEPTH);
	endfunction

	function automatic logic [31:0] rd_word(longint a);
		logic [31:0] v;
		v = '0;
		for (int k = 0; k < 4; k++)
			v[8*k +: 8] = mirror_mem[wrap(a + k)];
		return v;
	endfunction

	task automatic wr_word(longint a, logic [31:0] v);
		for (int k = 0; k < 4; k++)
			mirror_mem[wrap(a + k)] = v[8*k +: 8];
	endtask

	task automatic set_bytes(longint a, longint n, logic [7:0] v);
		for (longint i = 0; i < n; i++)
			mirror_mem[wrap(a + i)] = v;
	endtask

	task automatic wipe_arena();
		for (int i = 0; i < ARENA_DEPTH; i++)
			mirror_mem[i] = 8'h00;
		mirror_first = '0;
		mirror_empty = 1'b1;
	endtask

	function automatic longint arena_limit();
		return (mirror_used < ARENA_DEPTH) ? longint'(mirror_used) : longint'(ARENA_DEPTH);
	endfunction

	task automatic place_block(output longint data_idx, input logic [CW-1:0] sz);
		longint need, lim, blk_end;
		logic [31:0] cur, nxt;
		int nb;
		need = HDR_BYTES + sz;
		lim = arena_limit();
		data_idx = 0;
		if (lim < need) return;
		if (mirror_empty) begin
			mirror_first = '0;
			wr_word(OFS_NEXT, 0);
			wr_word(OFS_PREV, 0);
			wr_word(OFS_SIZE, sz);
			mirror_empty = 1'b0;
			data_idx = HDR_BYTES;
			return;
		end
		if (longint'(mirror_first) >= need) begin
			wr_word(longint'(mirror_first) + OFS_PREV, 0);
			wr_word(OFS_NEXT, mirror_first);
			wr_word(OFS_PREV, 0);
			wr_word(OFS_SIZE, sz);
			mirror_first = '0;
			data_idx = HDR_BYTES;
			return;
		end
		cur = mirror_first;
		for (int steps = 0; steps < ARENA_DEPTH; steps++) begin
			nxt = rd_word(cur + OFS_NEXT);
			blk_end = longint'(cur) + HDR_BYTES + longint'(rd_word(cur + OFS_SIZE));
			if (nxt == 0) begin
				if (blk_end + need <= lim) begin
					nb = wrap(blk_end);
					wr_word(nb + OFS_NEXT, 0);
					wr_word(nb + OFS_PREV, cur);
					wr_word(nb + OFS_SIZE, sz);
					wr_word(cur + OFS_NEXT, nb);
					data_idx = nb + HDR_BYTES;
				end
				return;
			end
			if (longint'(nxt) >= blk_end && longint'(nxt) - blk_end >= need) begin
				nb = wrap(blk_end);
				wr_word(nb + OFS_NEXT, nxt);
				wr_word(nb + OFS_PREV, cur);
				wr_word(nb + OFS_SIZE, sz);
				wr_word(cur + OFS_NEXT, nb);
				wr_word(longint'(nxt) + OFS_PREV, nb);
				data_idx = nb + HDR_BYTES;
				return;
			end
			cur = wrap(nxt);
		end
	endtask

	task automatic release_block(logic [AW-1:0] idx);
		int hdr;
		longint cnt;
		logic [31:0] n, p;
		bit is_first, is_last;
		hdr = wrap(longint'(idx) + ARENA_DEPTH - HDR_BYTES);
		cnt = rd_word(hdr + OFS_SIZE);
		if (cnt > ARENA_DEPTH) cnt = ARENA_DEPTH;
		set_bytes(idx, cnt, 8'h00);
		wr_word(hdr + OFS_SIZE, 0);
		if (mirror_empty) return;
		n = rd_word(hdr + OFS_NEXT);
		p = rd_word(hdr + OFS_PREV);
		is_first = (hdr == mirror_first);
		is_last = (n == 0);
		if (is_first && is_last) begin
			mirror_empty = 1'b1;
			mirror_first = '0;
		end else if (is_first) begin
			wr_word(longint'(n) + OFS_PREV, 0);
			mirror_first = wrap(n);
			wr_word(hdr + OFS_NEXT, 0);
		end else if (is_last) begin
			wr_word(longint'(p) + OFS_NEXT, 0);
			wr_word(hdr + OFS_PREV, 0);
		end else begin
			wr_word(longint'(p) + OFS_NEXT, n);
			wr_word(longint'(n) + OFS_PREV, p);
			wr_word(hdr + OFS_NEXT, 0);
			wr_word(hdr + OFS_PREV, 0);
		end
	endtask

	task automatic fill_blocks(logic [AW-1:0] idx, logic [CW-1:0] sz, logic [7:0] v);
		int hdr;
		longint pos, rem, ds;
		logic [31:0] n;
		hdr = wrap(longint'(idx) + ARENA_DEPTH - HDR_BYTES);
		pos = idx;
		rem = sz;
		ds = rd_word(hdr + OFS_SIZE);
		for (int visits = 0; rem != 0 && visits <= ARENA_DEPTH; visits++) begin
			if (ds >= rem) begin
				set_bytes(pos, rem, v);
				return;
			end
			set_bytes(pos, ds, v);
			rem -= ds;
			n = rd_word(hdr + OFS_NEXT);
			if (n == 0) return;
			hdr = wrap(n);
			ds = rd_word(hdr + OFS_SIZE);
			pos = hdr + HDR_BYTES;
		end
	endtask

	task automatic predict_result(output logic [AW-1:0] res, input func_t f,
			input logic [CW-1:0] sz, input logic [AW-1:0] idx, input logic [7:0] v);
		longint r;
		r = 0;
		case (f)
			FN_ALLOC: place_block(r, sz);
			FN_FREE:  release_block(idx);
			FN_FILL:  fill_blocks(idx, sz, v);
			default:  r = mirror_mem[idx];
		endcase
		res = r[AW-1:0];
	endtask

	// sends one item, with the sender's burst/gap pattern ahead of it
	task automatic send_item(func_t f, logic [CW-1:0] sz, logic [AW-1:0] idx,
			logic [7:0] v);
		logic [AW-1:0] r;
		@(posedge clk);
		if (sender_burst_gaps && $urandom_range(0, 5) == 0)
			repeat ($urandom_range(1, 12)) @(posedge clk);
		in_valid <= 1'b1;
		func <= f;
		size <= sz;
		index <= idx;
		value <= v;
		do @(posedge clk); while (in_stall);
		predict_result(r, f, sz, idx, v);
		expected_results.push_back(r);
		if (f == FN_ALLOC && r != 0) live_blocks.push_back(r);
		if (f == FN_FREE) begin
			for (int i = 0; i < live_blocks.size(); i++)
				if (live_blocks[i] == idx) begin
					live_blocks.delete(i);
					break;
				end
		end
		in_valid <= 1'b0;
	endtask

	task automatic drain();
		while (expected_results.size() != 0) @(posedge clk);
		// settle before anything else is driven
		repeat (20) @(posedge clk);
	endtask

	task automatic write_arena_size(logic [CW-1:0] sz);
		drain();
		cfg_valid <= 1'b1;
		arena_bytes_used <= sz;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		mirror_used = sz;
		wipe_arena();
		live_blocks.delete();
	endtask

	function automatic logic [AW-1:0] pick_block();
		if (live_blocks.size() == 0) return AW'(HDR_BYTES);
		return AW'(live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
	endfunction

	task automatic test_directed();
		send_item(FN_READ, 0, 0, 0);
		send_item(FN_FREE, 0, HDR_BYTES, 0);      // free while empty
		send_item(FN_ALLOC, 13'd4096, 0, 0);      // too large
		send_item(FN_ALLOC, 13'd8191, 0, 0);
		send_item(FN_ALLOC, 0, 0, 0);
		send_item(FN_ALLOC, 13'd20, 0, 0);
		send_item(FN_ALLOC, 13'd5, 0, 0);
		send_item(FN_FILL, 13'd8191, HDR_BYTES, 8'hFF); // walks across blocks
		send_item(FN_READ, 0, 12'd30, 0);
		send_item(FN_FREE, 0, 12'd24, 0);         // middle block
		send_item(FN_ALLOC, 13'd8, 0, 0);         // reuses gap
		send_item(FN_FREE, 0, HDR_BYTES, 0);      // first block
		send_item(FN_ALLOC, 0, 0, 0);             // before first block
		send_item(FN_FILL, 13'd3, 12'd4095, 8'hA5); // bogus index, address wrap
		send_item(FN_READ, 0, 12'd4095, 0);
		send_item(FN_READ, 0, 12'd0, 0);
		send_item(FN_FREE, 0, 12'd0, 0);          // bogus header below zero
		send_item(FN_FILL, 0, HDR_BYTES, 8'h5A);
		send_item(FN_ALLOC, 13'd4000, 0, 0);
		send_item(FN_READ, 0, 12'hAAA, 0);
		send_item(FN_READ, 0, 12'h555, 0);
	endtask

	task automatic test_small_arena();
		write_arena_size(13'd0);
		send_item(FN_ALLOC, 0, 0, 0);
		write_arena_size(13'd12);
		send_item(FN_ALLOC, 0, 0, 0);             // exact fit
		send_item(FN_ALLOC, 0, 0, 0);
		send_item(FN_FREE, 0, HDR_BYTES, 0);
		write_arena_size(13'd8191);               // capped at arena depth
		send_item(FN_ALLOC, 13'd4084, 0, 0);
		send_item(FN_READ, 0, 12'd8, 0);
	endtask

	task automatic random_ops(int n);
		func_t f;
		logic [CW-1:0] sz;
		logic [AW-1:0] idx;
		int sel;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(0, 99);
			sz = CW'($urandom_range(0, 64));
			idx = pick_block();
			if (sel < 35) f = FN_ALLOC;
			else if (sel < 55) f = FN_FREE;
			else if (sel < 70) f = FN_FILL;
			else f = FN_READ;
			if (f == FN_ALLOC && $urandom_range(0, 15) == 0) sz = CW'($urandom_range(0, 8191));
			if (f == FN_FILL && $urandom_range(0, 7) == 0) sz = CW'($urandom_range(0, 8191));
			if (f == FN_READ || $urandom_range(0, 19) == 0) idx = AW'($urandom_range(0, 4095));
			send_item(f, sz, idx, 8'($urandom_range(0, 255)));
		end
	endtask

	task automatic test_random();
		sender_burst_gaps = 1'b1;
		write_arena_size(13'd4096);
		random_ops(200);
		write_arena_size(13'd600);                // small arena, fills up often
		random_ops(150);
		// sender waits for all outstanding results before going on
		drain();
		random_ops(50);
		hold_off = 300;                           // receiver blocks, input backs up
		random_ops(40);
		write_arena_size(CW'($urandom_range(100, 4096)));
		random_ops(160);
	endtask

	// receiver stall pattern plus the requested long hold-off
	initial begin
		out_stall = 1'b0;
		hold_off = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_off > 0) begin
				out_stall <= 1'b1;
				hold_off--;
			end else begin
				case ($urandom_range(0, 3))
					0: out_stall <= ($urandom_range(0, 1) == 0);
					default: out_stall <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	// result checker
	initial begin
		logic [AW-1:0] want;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result %0d", $time, result);
					failed = 1'b1;
				end else begin
					want = expected_results.pop_front();
					if (result !== want) begin
						$display("%0t: result mismatch expected %0d actual %0d",
							$time, want, result);
						failed = 1'b1;
					end
				end
			end
		end
	end

	// watchdog on cycles with no handshake on any channel
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("** first_fit_arena_allocator_top: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		failed = 1'b0;
		sender_burst_gaps = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FN_ALLOC;
		size = '0;
		index = '0;
		value = '0;
		cfg_valid = 1'b0;
		arena_bytes_used = 13'd4096;
		mirror_used = 13'd4096;
		wipe_arena();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_small_arena();
		test_random();
		drain();
		repeat (50) @(posedge clk);
		if (!failed)
			$display("** first_fit_arena_allocator_top: PASSED **");
		else
			$display("** first_fit_arena_allocator_top: FAILED **");
		$finish;
	end
endmodule
